// ===== rtl/core/pru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

  // Default geometry
  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int ROW_LEN_W  = 14;
  localparam int BPP_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;

  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = 14'd1;
  localparam logic [BPP_W-1:0]     BPP_RST     = 4'd1;

  // Row filter codes
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam logic [BYTE_W-1:0] FILT_MAX_CODE = 8'd4;

  // Control flags of one item on its way into the reconstruction stage
  typedef struct packed {
    logic  bad;
    logic  last;
    logic  has_left;
    logic  prior_valid;
    filt_t filt;
  } pru_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pru_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pru_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pru_ctrl #(
  parameter int COL_W = 13,
  parameter int CW    = 14
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_fire,
  input  wire logic [pru_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                      in_start,
  input  wire logic [CW-1:0]             eff_len,
  input  wire logic [pru_pkg::BPP_W-1:0] eff_bpp,
  output logic                           push,
  output pru_pkg::pru_item_t             push_item,
  output logic      [COL_W-1:0]          push_col
);

  import pru_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  filt_t            filt_r, filt_nxt;
  logic             pv_r, pv_nxt;
  logic             await_r, await_nxt;
  logic             err_r, err_nxt;

  logic             err_eff, await_eff, pv_eff;
  logic [COL_W:0]   col_inc;
  logic             last;
  logic             has_left;

  assign err_eff   = in_start ? 1'b0 : err_r;
  assign await_eff = in_start ? 1'b1 : await_r;
  assign pv_eff    = in_start ? 1'b0 : pv_r;

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign last     = CW'(col_inc) >= eff_len;
  assign has_left = CW'(col_r) >= CW'(eff_bpp);
  assign push_col = col_r;

  always_comb begin
    col_nxt   = col_r;
    filt_nxt  = filt_r;
    pv_nxt    = pv_r;
    await_nxt = await_r;
    err_nxt   = err_r;
    push      = 1'b0;
    push_item = '0;
    if (in_fire) begin
      err_nxt   = err_eff;
      await_nxt = await_eff;
      pv_nxt    = pv_eff;
      if (!err_eff) begin
        if (await_eff) begin
          col_nxt = '0;
          if (in_byte > FILT_MAX_CODE) begin
            err_nxt       = 1'b1;
            push          = 1'b1;
            push_item.bad = 1'b1;
          end else begin
            filt_nxt  = filt_t'(in_byte[2:0]);
            await_nxt = 1'b0;
          end
        end else begin
          push                  = 1'b1;
          push_item.last        = last;
          push_item.has_left    = has_left;
          push_item.prior_valid = pv_eff;
          push_item.filt        = filt_r;
          if (last) begin
            col_nxt   = '0;
            await_nxt = 1'b1;
            pv_nxt    = 1'b1;
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      filt_r  <= FILT_NONE;
      pv_r    <= 1'b0;
      await_r <= 1'b1;
      err_r   <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      filt_r  <= filt_nxt;
      pv_r    <= pv_nxt;
      await_r <= await_nxt;
      err_r   <= err_nxt;
    end
  end

  // Only a new pass start may push again right after a bad filter code
  a_bad_latches: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_item.bad |=> err_r && (!push || in_start))
    else $error("bad filter result not followed by error latch");

  a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    push && !push_item.bad && push_item.last |=> await_r && pv_r && (col_r == '0))
    else $error("row end did not rearm filter byte");

  a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
    push && !push_item.bad && !push_item.last |=> col_r == $past(col_r) + 1'b1)
    else $error("column index did not advance");

endmodule

`default_nettype wire

// ===== rtl/core/pru_recon.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pru_recon #(
  parameter int COL_W           = 13,
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int BPP_IW          = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  pru_pkg::pru_item_t              push_item,
  input  wire logic [pru_pkg::BYTE_W-1:0] push_byte,
  input  wire logic [COL_W-1:0]           push_col,
  input  wire logic [pru_pkg::BYTE_W-1:0] up_rdata,
  input  wire logic [BPP_IW-1:0]          bpp_sel,
  input  wire logic                       out_stall,
  output logic                            hold,
  output logic                            ram_we,
  output logic      [COL_W-1:0]           ram_waddr,
  output logic      [pru_pkg::BYTE_W-1:0] ram_wdata,
  output logic                            out_valid,
  output logic      [pru_pkg::BYTE_W-1:0] out_pixel_byte,
  output logic                            out_row_end,
  output logic                            out_bad_filter
);

  import pru_pkg::*;

  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic signed [9:0] da, db, dc;
    logic        [9:0] pa, pb, pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

  logic              s1_valid_r;
  pru_item_t         s1_item_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [COL_W-1:0]  s1_col_r;

  logic [BYTE_W-1:0] left_hist_r [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] up_hist_r   [MAX_PIXEL_BYTES];

  logic              go, load, fire;
  logic [BYTE_W-1:0] up, left, corner, pred, value;
  logic [BYTE_W:0]   avg_sum;

  assign go   = !out_valid || !out_stall;
  assign load = !s1_valid_r || go;
  assign fire = s1_valid_r && go;
  assign hold = !load;

  assign up      = s1_item_r.prior_valid ? up_rdata : '0;
  assign left    = s1_item_r.has_left ? left_hist_r[bpp_sel] : '0;
  assign corner  = (s1_item_r.prior_valid && s1_item_r.has_left) ? up_hist_r[bpp_sel] : '0;
  assign avg_sum = {1'b0, left} + {1'b0, up};

  always_comb begin
    case (s1_item_r.filt)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth(left, up, corner);
      default:    pred = '0;
    endcase
  end

  assign value = s1_item_r.bad ? '0 : s1_byte_r + pred;

  assign ram_we    = fire && !s1_item_r.bad;
  assign ram_waddr = s1_col_r;
  assign ram_wdata = value;

  // Stage and output registers with control reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_r <= push;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      s1_item_r <= push_item;
      s1_byte_r <= push_byte;
      s1_col_r  <= push_col;
    end
    if (fire) begin
      out_pixel_byte <= value;
      out_row_end    <= s1_item_r.last && !s1_item_r.bad;
      out_bad_filter <= s1_item_r.bad;
    end
    if (fire && !s1_item_r.bad) begin
      left_hist_r[0] <= value;
      up_hist_r[0]   <= up;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_r[i] <= left_hist_r[i-1];
        up_hist_r[i]   <= up_hist_r[i-1];
      end
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_filter |-> (out_pixel_byte == '0) && !out_row_end)
    else $error("bad filter result carries data");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_byte_r))
    else $error("held stage lost its item");

  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("fired item not presented");

endmodule

`default_nettype wire

// ===== rtl/core/png_row_unfilter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PNG row unfilter: streaming reconstruction of filtered scanlines.
//
// Input channel (in_valid / in_stall): one byte of the inflated image stream
// per item. Each row is a filter-type byte followed by row_length data bytes.
// in_pass_start marks the first byte of a pass; that byte is taken as a filter
// byte and the first row of the pass has no row above it.
// Output channel (out_valid / out_stall): one item per data byte, carrying the
// reconstructed byte and a row_end mark. A filter type above 4 gives a single
// item with out_bad_filter set; bytes are then dropped until the next
// pass start. Filter bytes and dropped bytes give no item.
// Config port (cfg_valid / cfg_ready, always ready): index 0 is row_length,
// index 1 is bytes_per_pixel. Write only while the block is idle.
// Throughput: one item per cycle while the receiver does not stall. The stage
// loads on the accepting edge, which also starts the line store read; the
// output register loads from the stage when the stage fires.
// The line store is a single RAM read one column ahead and written back when
// the byte is reconstructed. When the receiver stalls, the output register
// holds, the stage takes one more item and holds, then in_stall follows out_stall.
// Reset clears control state and config; the line store is not cleared.

module png_row_unfilter_core #(
  parameter int MAX_ROW_BYTES   = pru_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pru_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pru_pkg::BYTE_W-1:0]     in_filtered_byte,
  input  wire logic                           in_pass_start,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [pru_pkg::BYTE_W-1:0]     out_pixel_byte,
  output logic                                out_row_end,
  output logic                                out_bad_filter,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data
);

  import pru_pkg::*;

  localparam int COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int CW     = (COL_W + 1 > ROW_LEN_W) ? COL_W + 1 : ROW_LEN_W;
  localparam int BPP_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [ROW_LEN_W-1:0] row_len_r;
  logic [BPP_W-1:0]     bpp_r;
  logic [CW-1:0]        eff_len;
  logic [BPP_W-1:0]     eff_bpp;
  logic [BPP_IW-1:0]    bpp_sel;

  logic                 in_fire;
  logic                 push;
  pru_item_t            push_item;
  logic [COL_W-1:0]     push_col;
  logic                 hold;

  logic                 ram_re;
  logic                 ram_we;
  logic [COL_W-1:0]     ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic [BYTE_W-1:0]    ram_rdata;

  assign cfg_ready = 1'b1;

  // Config registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= ROW_LEN_RST;
      bpp_r     <= BPP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_LENGTH:      row_len_r <= cfg_data[ROW_LEN_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_r     <= cfg_data[BPP_W-1:0];
        default:             ;
      endcase
    end
  end

  // Clamp config into the supported range: zero acts as one
  always_comb begin
    if (row_len_r == '0) begin
      eff_len = CW'(1);
    end else if (CW'(row_len_r) > CW'(MAX_ROW_BYTES)) begin
      eff_len = CW'(MAX_ROW_BYTES);
    end else begin
      eff_len = CW'(row_len_r);
    end
    if (bpp_r == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_PIXEL_BYTES)) begin
      eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = bpp_r;
    end
  end

  assign bpp_sel  = BPP_IW'(eff_bpp - 1'b1);
  assign in_stall = hold;
  assign in_fire  = in_valid && !in_stall;

  // Read the row above as the byte enters the reconstruction stage
  assign ram_re = push && !push_item.bad;

  pru_ctrl #(
    .COL_W (COL_W),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_filtered_byte),
    .in_start  (in_pass_start),
    .eff_len   (eff_len),
    .eff_bpp   (eff_bpp),
    .push      (push),
    .push_item (push_item),
    .push_col  (push_col)
  );

  pru_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (push_col),
    .rdata (ram_rdata)
  );

  pru_recon #(
    .COL_W           (COL_W),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .BPP_IW          (BPP_IW)
  ) u_recon (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .push_item      (push_item),
    .push_byte      (in_filtered_byte),
    .push_col       (push_col),
    .up_rdata       (ram_rdata),
    .bpp_sel        (bpp_sel),
    .out_stall      (out_stall),
    .hold           (hold),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .out_valid      (out_valid),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end),
    .out_bad_filter (out_bad_filter)
  );

  // A filter byte always separates a write-back from a read of the same column
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re && ram_we |-> push_col != ram_waddr)
    else $error("line store read and write collide");

  a_no_push_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> !push)
    else $error("item pushed into held stage");

endmodule

`default_nettype wire

// ===== test/png_row_unfilter_core_test.sv =====
`timescale 1ns / 1ps

module png_row_unfilter_core_test;
  import pru_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 9;
  localparam int DRAIN_WAIT  = 8;        // two-stage pipeline plus margin
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 45;

  // Index 2 is not in the register map; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              row_end;
    logic              bad;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_filtered_byte = '0;
  logic                  in_pass_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_pixel_byte;
  logic                  out_row_end;
  logic                  out_bad_filter;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Idling knobs, in percent of cycles
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  int cycle_count = 0;
  int mismatches = 0;
  int bytes_sent = 0;

  // Shadow of the unfilter state, advanced once per accepted item
  logic [ROW_LEN_W-1:0] row_len_reg = ROW_LEN_RST;
  logic [BPP_W-1:0]     bpp_reg = BPP_RST;
  logic [BYTE_W-1:0]    above_row [MAX_ROW_BYTES_DEF];
  logic [63:0]          left_hist = '0;
  logic [63:0]          corner_hist = '0;
  int unsigned          col = 0;
  filt_t                row_filt = FILT_NONE;
  logic                 above_ok = 1'b0;
  logic                 want_filter = 1'b1;
  logic                 err_latched = 1'b0;

  pixel_result_t pending_pixels [$];

  png_row_unfilter_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_filtered_byte (in_filtered_byte),
    .in_pass_start    (in_pass_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_byte   (out_pixel_byte),
    .out_row_end      (out_row_end),
    .out_bad_filter   (out_bad_filter),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result channel at the current rate; decide at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare every accepted result with the oldest pending reconstruction.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected item, expected none, got pixel %02h row_end %0b bad %0b",
                 $time, out_pixel_byte, out_row_end, out_bad_filter);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_byte !== want.pixel) begin
          $display("%0t: pixel_byte mismatch, expected %02h, got %02h",
                   $time, want.pixel, out_pixel_byte);
          mismatches++;
        end
        if (out_row_end !== want.row_end) begin
          $display("%0t: row_end mismatch, expected %0b, got %0b",
                   $time, want.row_end, out_row_end);
          mismatches++;
        end
        if (out_bad_filter !== want.bad) begin
          $display("%0t: bad_filter mismatch, expected %0b, got %0b",
                   $time, want.bad, out_bad_filter);
          mismatches++;
        end
      end
    end
  end

  // Effective geometry: zero acts as one, large values clamp.
  function automatic int unsigned eff_row_len();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > MAX_ROW_BYTES_DEF) return MAX_ROW_BYTES_DEF;
    return row_len_reg;
  endfunction

  function automatic int unsigned pixel_bytes();
    if (bpp_reg == 0) return 1;
    if (bpp_reg > MAX_PIXEL_BYTES_DEF) return MAX_PIXEL_BYTES_DEF;
    return bpp_reg;
  endfunction

  // Paeth predictor; ties go to left, then up, then the corner.
  function automatic logic [BYTE_W-1:0] paeth_guess(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] c);
    int est;
    int da;
    int db;
    int dc;
    est = int'(a) + int'(b) - int'(c);
    da = est - int'(a);
    db = est - int'(b);
    dc = est - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

  // Advance the shadow state by one accepted item; queue the pixel it yields.
  task automatic reconstruct_byte(input logic [BYTE_W-1:0] b, input logic ps);
    int unsigned   sh;
    logic          has_left;
    logic          last;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] corner;
    logic [BYTE_W-1:0] guess;
    logic [BYTE_W-1:0] value;
    pixel_result_t     res;
    if (ps) begin
      err_latched = 1'b0;
      above_ok = 1'b0;
      want_filter = 1'b1;
    end
    if (err_latched) return;

    // Filter byte: restart the row and select the filter, or latch an error on a bad code
    if (want_filter) begin
      left_hist = '0;
      corner_hist = '0;
      col = 0;
      if (b > FILT_MAX_CODE) begin
        err_latched = 1'b1;
        res.pixel = '0;
        res.row_end = 1'b0;
        res.bad = 1'b1;
        pending_pixels.push_back(res);
        return;
      end
      row_filt = filt_t'(b[2:0]);
      want_filter = 1'b0;
      return;
    end

    sh = (pixel_bytes() - 1) * 8;
    has_left = (col >= pixel_bytes());
    left = has_left ? left_hist[sh +: 8] : '0;
    up = above_ok ? above_row[col] : '0;
    corner = (above_ok && has_left) ? corner_hist[sh +: 8] : '0;
    case (row_filt)
      FILT_SUB:   guess = left;
      FILT_UP:    guess = up;
      FILT_AVG:   guess = 8'((9'(left) + 9'(up)) >> 1);
      FILT_PAETH: guess = paeth_guess(left, up, corner);
      default:    guess = '0;
    endcase
    value = b + guess;

    corner_hist = {corner_hist[55:0], up};
    left_hist = {left_hist[55:0], value};
    above_row[col] = value;

    last = (col + 1 >= eff_row_len());
    if (last) begin
      col = 0;
      want_filter = 1'b1;
      above_ok = 1'b1;
    end else begin
      col = col + 1;
    end

    res.pixel = value;
    res.row_end = last;
    res.bad = 1'b0;
    pending_pixels.push_back(res);
  endtask

  // Send one stream byte: idle at random, then hold until accepted.
  task automatic send_stream_byte(input logic [BYTE_W-1:0] b, input logic ps);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_filtered_byte <= b;
    in_pass_start <= ps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    reconstruct_byte(b, ps);
  endtask

  // Drop valid, wait for every pending pixel, then let the pipeline empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROW_LENGTH:      row_len_reg = value;
      REG_BYTES_PER_PIXEL: bpp_reg = value[BPP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // One pass of well-formed rows with random content. Now and then break it:
  // a bad filter code followed by junk, or a row cut short by the next pass.
  task automatic send_random_pass();
    int rows;
    int r;
    int c;
    rows = $urandom_range(1, 5);
    for (r = 0; r < rows; r++) begin
      if ($urandom_range(19) == 0) begin
        send_stream_byte(8'($urandom_range(255, 5)), r == 0);
        repeat ($urandom_range(3)) send_stream_byte(8'($urandom), 1'b0);
        return;
      end
      send_stream_byte(8'($urandom_range(4)), r == 0);
      for (c = 0; c < eff_row_len(); c++) begin
        if ($urandom_range(99) == 0) return;
        send_stream_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Reset geometry (one byte per row): a plain row, a bad code, a dropped
  // byte, and a new pass that opens with a bad code.
  task automatic test_bad_filter_recovery();
    set_idling(0, 0);
    send_stream_byte(8'(FILT_UP), 1'b1);
    send_stream_byte(8'h5A, 1'b0);
    send_stream_byte(FILT_MAX_CODE + 8'd1, 1'b0);
    send_stream_byte(8'h00, 1'b0);
    send_stream_byte(8'hFF, 1'b1);
    drain();
  endtask

  // Every filter on two-byte rows, starting with no row above, then a row cut
  // short by a pass start.
  task automatic test_filter_rows();
    write_reg(REG_ROW_LENGTH, 14'd2);
    write_reg(REG_BYTES_PER_PIXEL, 14'd1);
    set_idling(8, 8);
    send_stream_byte(8'(FILT_PAETH), 1'b1);
    send_stream_byte(8'hFF, 1'b0);
    send_stream_byte(8'h80, 1'b0);
    send_stream_byte(8'(FILT_NONE), 1'b0);
    send_stream_byte(8'h00, 1'b0);
    send_stream_byte(8'hFF, 1'b0);
    send_stream_byte(8'(FILT_SUB), 1'b0);
    send_stream_byte(8'hFF, 1'b0);
    send_stream_byte(8'h01, 1'b0);
    send_stream_byte(8'(FILT_UP), 1'b0);
    send_stream_byte(8'h7F, 1'b0);
    send_stream_byte(8'h80, 1'b0);
    send_stream_byte(8'(FILT_AVG), 1'b0);
    send_stream_byte(8'hFF, 1'b0);
    send_stream_byte(8'hFF, 1'b0);
    send_stream_byte(8'(FILT_PAETH), 1'b0);
    send_stream_byte(8'h12, 1'b0);
    send_stream_byte(8'h34, 1'b0);
    // abandon this row: the up row that follows has nothing above it
    send_stream_byte(8'(FILT_SUB), 1'b0);
    send_stream_byte(8'h55, 1'b0);
    send_stream_byte(8'(FILT_UP), 1'b1);
    send_stream_byte(8'h01, 1'b0);
    send_stream_byte(8'h02, 1'b0);
    drain();
  endtask

  // Random passes over a range of geometries and every idling pattern.
  // The byte-per-pixel writes carry random upper bits, which must be ignored.
  task automatic test_random_geometry();
    logic [ROW_LEN_W-1:0] lens [8];
    logic [BPP_W-1:0]     bpps [8];
    int p;
    int start;
    lens = '{14'd1, 14'd0, 14'd2, 14'd7, 14'd12, 14'd5, 14'd33, 14'd3};
    bpps = '{4'd1, 4'd0, 4'd8, 4'd3, 4'd15, 4'd6, 4'd2, 4'd4};
    for (p = 0; p < 8; p++) begin
      write_reg(REG_ROW_LENGTH, lens[p]);
      write_reg(REG_BYTES_PER_PIXEL, {10'($urandom), bpps[p]});
      if (p == 5) write_reg(REG_SPARE, 14'h3FFF);
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(48, 0);
        2: set_idling(0, 48);
        default: set_idling(8, 8);
      endcase
      start = bytes_sent;
      while (bytes_sent - start < PHASE_ITEMS) send_random_pass();
      drain();
    end
  endtask

  // Two longer rows with the widest pixel: sub, then Paeth over it.
  task automatic test_longest_row();
    int c;
    write_reg(REG_ROW_LENGTH, 14'd24);
    write_reg(REG_BYTES_PER_PIXEL, 14'd8);
    set_idling(8, 8);
    send_stream_byte(8'(FILT_SUB), 1'b1);
    for (c = 0; c < eff_row_len(); c++) send_stream_byte(8'($urandom), 1'b0);
    send_stream_byte(8'(FILT_PAETH), 1'b0);
    for (c = 0; c < eff_row_len(); c++) send_stream_byte(8'($urandom), 1'b0);
    drain();
  endtask

  initial begin
    // hold reset, release at a falling edge
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_bad_filter_recovery();
    test_filter_rows();
    test_random_geometry();
    test_longest_row();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
